// File: src/assert_macros.svh
// Assertion macros shared by the readback unit RTL.
// No dependencies; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("label");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("label");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: src/spru_pkg.sv
// Package for the surface pixel readback unit: payload structs, command codes,
// sizes and the queue entry type. No dependencies.
package spru_pkg;
   localparam int SURFACE_COUNT = 4;
   localparam int CHUNK_PIXELS = 64;
   localparam int MAX_SURFACE_WIDTH = 256;
   localparam int MAX_SURFACE_HEIGHT = 256;
   localparam int SID_BITS = (SURFACE_COUNT > 1) ? $clog2(SURFACE_COUNT) : 1;
   localparam int CHUNK_BITS = (CHUNK_PIXELS > 1) ? $clog2(CHUNK_PIXELS) : 1;
   localparam int CW_BITS = $clog2(CHUNK_PIXELS + 1);
   localparam int MW_BITS = (MAX_SURFACE_WIDTH > 1) ? $clog2(MAX_SURFACE_WIDTH) : 1;
   localparam int MH_BITS = (MAX_SURFACE_HEIGHT > 1) ? $clog2(MAX_SURFACE_HEIGHT) : 1;
   localparam int SURF_ADDR_BITS = SID_BITS + MW_BITS + MH_BITS;
   localparam int CACHE_ADDR_BITS = SID_BITS + CHUNK_BITS;

   typedef enum logic [2:0] {
      KIND_BEGIN_FRAME = 3'd0,
      KIND_REGISTER = 3'd1,
      KIND_INVALIDATE = 3'd2,
      KIND_RESET_REGISTRY = 3'd3,
      KIND_RESOLVE = 3'd4,
      KIND_READ_PIXEL = 3'd5,
      KIND_LOAD_PIXEL = 3'd6,
      KIND_UNUSED = 3'd7
   } kind_type;

   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_MODE = 2'd1;
   localparam logic [1:0] FAULT_SURFACE = 2'd2;
   localparam logic [1:0] FAULT_BOUNDS = 2'd3;

   localparam logic CSR_FRAME_BUDGET = 1'b0;
   localparam logic CSR_MODE_CODE = 1'b1;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] surface_id;
      logic [7:0] mode;
      logic [15:0] x;
      logic [15:0] y;
      logic [8:0] surface_width;
      logic [8:0] surface_height;
      logic [31:0] pixel_data;
   } req_type;

   typedef struct packed {
      logic ok;
      logic [31:0] read_word;
      logic [1:0] fault_code;
      logic [31:0] fault_detail;
      logic advance;
      logic [15:0] next_x;
      logic [16:0] next_y;
      logic status_ready;
      logic status_overflow;
   } rsp_type;

   // Classified item handed from the front part to the back part.
   typedef struct packed {
      kind_type kind;
      logic sid_valid;
      logic [SID_BITS-1:0] sid;
      logic [7:0] surface_id;
      logic [7:0] mode;
      logic [15:0] x;
      logic [15:0] y;
      logic [8:0] surface_width;
      logic in_bounds;
      logic load_ok;
      logic [31:0] pixel_data;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_HIT_RD,
      ST_HIT_DONE
   } back_state_type;
endpackage

// File: src/spru_front.sv
// Front part: accepts command items and classifies them into queue entries.
// Depends on spru_pkg.
module spru_front (
   input logic start,
   input spru_pkg::req_type req_item,
   input logic q_full,
   output logic busy,
   output logic q_push,
   output spru_pkg::entry_type q_entry
);
   spru_pkg::entry_type e;

   assign busy = q_full;
   assign q_push = start && !q_full;

   always_comb begin
      e = '0;
      e.kind = spru_pkg::kind_type'(req_item.kind);
      e.sid_valid = {24'd0, req_item.surface_id} < spru_pkg::SURFACE_COUNT;
      e.sid = req_item.surface_id[spru_pkg::SID_BITS-1:0];
      e.surface_id = req_item.surface_id;
      e.mode = req_item.mode;
      e.x = req_item.x;
      e.y = req_item.y;
      e.surface_width = req_item.surface_width;
      e.in_bounds = ({7'd0, req_item.surface_width} > req_item.x)
         && ({7'd0, req_item.surface_height} > req_item.y);
      e.load_ok = e.sid_valid && ({16'd0, req_item.x} < 32'(spru_pkg::MAX_SURFACE_WIDTH))
         && ({16'd0, req_item.y} < 32'(spru_pkg::MAX_SURFACE_HEIGHT));
      e.pixel_data = req_item.pixel_data;
   end

   assign q_entry = e;
endmodule

// File: src/spru_queue.sv
// Two-entry queue between the front and back parts.
// Depends on spru_pkg.
module spru_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input spru_pkg::entry_type push_entry,
   input logic pop,
   output logic full,
   output logic empty,
   output spru_pkg::entry_type head
);
   spru_pkg::entry_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end
endmodule

// File: src/spru_back.sv
// Back part: executes queued commands, owns budget, registry, chunk cache and
// surface memory, and drives the result strobe. Depends on spru_pkg.
module spru_back (
   input logic clock,
   input logic reset,
   input logic q_empty,
   input spru_pkg::entry_type head,
   output logic q_pop,
   input logic [23:0] frame_budget,
   input logic [7:0] mode_code,
   output logic done,
   output spru_pkg::rsp_type rsp_item
);
   localparam int SC = spru_pkg::SURFACE_COUNT;
   localparam int CB = spru_pkg::CHUNK_BITS;
   localparam int SB = spru_pkg::SID_BITS;
   localparam int WB = spru_pkg::CW_BITS;

   logic [31:0] surf_mem [2**spru_pkg::SURF_ADDR_BITS];
   logic [31:0] cache_mem [2**spru_pkg::CACHE_ADDR_BITS];

   spru_pkg::back_state_type state_ff, state_in;
   logic [23:0] budget_ff, budget_in;
   logic overflow_ff, overflow_in;
   logic [SC-1:0] reg_mask_ff, reg_mask_in;
   logic [SB-1:0] resolved_ff, resolved_in;
   logic [1:0] fault_ff, fault_in;
   logic [31:0] detail_ff, detail_in;
   logic advance_ff, advance_in;
   logic [31:0] word_ff, word_in;
   logic [15:0] next_x_ff, next_x_in;
   logic [16:0] next_y_ff, next_y_in;
   logic ok_ff, ok_in;
   logic done_ff, done_in;
   logic [WB-1:0] cwidth_ff [SC];
   logic [WB-1:0] cwidth_in [SC];
   logic [15:0] cstart_ff [SC];
   logic [15:0] cstart_in [SC];
   logic [15:0] crow_ff [SC];
   logic [15:0] crow_in [SC];
   logic [WB-1:0] fill_n_ff, fill_n_in;
   logic [WB-1:0] fill_i_ff, fill_i_in;

   logic [31:0] surf_rd_ff, cache_rd_ff;
   logic surf_zero_ff;
   logic [spru_pkg::SURF_ADDR_BITS-1:0] surf_addr;
   logic surf_outside;
   logic [spru_pkg::CACHE_ADDR_BITS-1:0] cache_waddr, cache_raddr;
   logic [15:0] cache_off;
   logic cache_we;
   logic [16:0] fill_x;
   logic [16:0] cend;
   logic hit;
   logic [9:0] avail_w;
   logic [21:0] avail_b;
   logic [WB-1:0] n_calc;
   logic [16:0] x_plus;

   always_comb begin
      fill_x = {1'b0, head.x} + {{(17-WB){1'b0}}, fill_i_ff};
      surf_outside = (fill_x >= 17'(spru_pkg::MAX_SURFACE_WIDTH))
         || ({16'd0, head.y} >= 32'(spru_pkg::MAX_SURFACE_HEIGHT));
      if (state_ff == spru_pkg::ST_IDLE) begin
         surf_addr = {head.sid, head.y[spru_pkg::MH_BITS-1:0], head.x[spru_pkg::MW_BITS-1:0]};
      end else begin
         surf_addr = {resolved_ff, head.y[spru_pkg::MH_BITS-1:0],
            fill_x[spru_pkg::MW_BITS-1:0]};
      end
      cache_waddr = {resolved_ff, fill_i_ff[CB-1:0] - 1'b1};
      cache_off = head.x - cstart_ff[resolved_ff];
      cache_raddr = {resolved_ff, cache_off[CB-1:0]};
      cend = {1'b0, cstart_ff[resolved_ff]} + {{(17-WB){1'b0}}, cwidth_ff[resolved_ff]};
      hit = (cwidth_ff[resolved_ff] != '0) && (crow_ff[resolved_ff] == head.y)
         && (head.x >= cstart_ff[resolved_ff]) && ({1'b0, head.x} < cend);
      avail_w = {1'b0, head.surface_width} - head.x[9:0];
      avail_b = budget_ff[23:2];
      n_calc = WB'(spru_pkg::CHUNK_PIXELS);
      if ({22'd0, avail_w} < 32'(n_calc)) n_calc = WB'(avail_w);
      if ({10'd0, avail_b} < 32'(n_calc)) n_calc = WB'(avail_b);
      x_plus = {1'b0, head.x} + 17'd1;
   end

   assign cache_we = (state_ff == spru_pkg::ST_FILL_WR);

   always_ff @(posedge clock) begin
      if (state_ff == spru_pkg::ST_IDLE && !q_empty && head.kind == spru_pkg::KIND_LOAD_PIXEL
          && head.load_ok) begin
         surf_mem[surf_addr] <= head.pixel_data;
      end
      surf_rd_ff <= surf_mem[surf_addr];
      surf_zero_ff <= surf_outside;
      if (cache_we) begin
         cache_mem[cache_waddr] <= surf_zero_ff ? 32'd0 : surf_rd_ff;
      end
      cache_rd_ff <= cache_mem[cache_raddr];
   end

   always_comb begin
      state_in = state_ff;
      budget_in = budget_ff;
      overflow_in = overflow_ff;
      reg_mask_in = reg_mask_ff;
      resolved_in = resolved_ff;
      fault_in = fault_ff;
      detail_in = detail_ff;
      advance_in = advance_ff;
      word_in = word_ff;
      next_x_in = next_x_ff;
      next_y_in = next_y_ff;
      cwidth_in = cwidth_ff;
      cstart_in = cstart_ff;
      crow_in = crow_ff;
      fill_n_in = fill_n_ff;
      fill_i_in = fill_i_ff;
      ok_in = 1'b0;
      done_in = 1'b0;
      q_pop = 1'b0;
      case (state_ff)
         spru_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               done_in = 1'b1;
               case (head.kind)
                  spru_pkg::KIND_BEGIN_FRAME: begin
                     budget_in = frame_budget;
                     overflow_in = 1'b0;
                  end
                  spru_pkg::KIND_REGISTER: begin
                     if (head.sid_valid) begin
                        reg_mask_in[head.sid] = 1'b1;
                        cwidth_in[head.sid] = '0;
                     end
                  end
                  spru_pkg::KIND_INVALIDATE: begin
                     if (head.sid_valid) cwidth_in[head.sid] = '0;
                  end
                  spru_pkg::KIND_RESET_REGISTRY: begin
                     reg_mask_in = '0;
                     for (int i = 0; i < SC; i++) cwidth_in[i] = '0;
                  end
                  spru_pkg::KIND_RESOLVE: begin
                     advance_in = 1'b0;
                     word_in = '0;
                     if (head.mode != mode_code) begin
                        fault_in = spru_pkg::FAULT_MODE;
                        detail_in = {24'd0, head.mode};
                     end else if (!head.sid_valid || !reg_mask_ff[head.sid]) begin
                        fault_in = spru_pkg::FAULT_SURFACE;
                        detail_in = {24'd0, head.surface_id};
                     end else begin
                        fault_in = spru_pkg::FAULT_NONE;
                        detail_in = '0;
                        resolved_in = head.sid;
                        ok_in = 1'b1;
                     end
                  end
                  spru_pkg::KIND_READ_PIXEL: begin
                     if (!head.in_bounds) begin
                        fault_in = spru_pkg::FAULT_BOUNDS;
                        detail_in = {head.y, head.x};
                        word_in = '0;
                     end else if (budget_ff < 24'd4) begin
                        overflow_in = 1'b1;
                        word_in = '0;
                        advance_in = 1'b0;
                        ok_in = 1'b1;
                     end else begin
                        q_pop = 1'b0;
                        done_in = 1'b0;
                        if (hit) begin
                           state_in = spru_pkg::ST_HIT_RD;
                        end else begin
                           fill_n_in = n_calc;
                           fill_i_in = '0;
                           state_in = spru_pkg::ST_FILL_RD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         spru_pkg::ST_FILL_RD: begin
            fill_i_in = fill_i_ff + 1'b1;
            state_in = spru_pkg::ST_FILL_WR;
         end
         spru_pkg::ST_FILL_WR: begin
            if (fill_i_ff >= fill_n_ff) begin
               cstart_in[resolved_ff] = head.x;
               crow_in[resolved_ff] = head.y;
               cwidth_in[resolved_ff] = fill_n_ff;
               state_in = spru_pkg::ST_HIT_RD;
            end else begin
               fill_i_in = fill_i_ff + 1'b1;
            end
         end
         spru_pkg::ST_HIT_RD: begin
            state_in = spru_pkg::ST_HIT_DONE;
         end
         spru_pkg::ST_HIT_DONE: begin
            q_pop = 1'b1;
            done_in = 1'b1;
            ok_in = 1'b1;
            word_in = cache_rd_ff;
            budget_in = budget_ff - 24'd4;
            advance_in = 1'b1;
            if (x_plus >= {8'd0, head.surface_width}) begin
               next_x_in = '0;
               next_y_in = {1'b0, head.y} + 17'd1;
            end else begin
               next_x_in = x_plus[15:0];
               next_y_in = {1'b0, head.y};
            end
            state_in = spru_pkg::ST_IDLE;
         end
         default: begin
            state_in = spru_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spru_pkg::ST_IDLE;
         budget_ff <= '0;
         overflow_ff <= 1'b0;
         reg_mask_ff <= '0;
         resolved_ff <= '0;
         fault_ff <= spru_pkg::FAULT_NONE;
         detail_ff <= '0;
         advance_ff <= 1'b0;
         word_ff <= '0;
         next_x_ff <= '0;
         next_y_ff <= '0;
         ok_ff <= 1'b0;
         done_ff <= 1'b0;
         fill_n_ff <= '0;
         fill_i_ff <= '0;
         for (int i = 0; i < SC; i++) begin
            cwidth_ff[i] <= '0;
            cstart_ff[i] <= '0;
            crow_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         budget_ff <= budget_in;
         overflow_ff <= overflow_in;
         reg_mask_ff <= reg_mask_in;
         resolved_ff <= resolved_in;
         fault_ff <= fault_in;
         detail_ff <= detail_in;
         advance_ff <= advance_in;
         word_ff <= word_in;
         next_x_ff <= next_x_in;
         next_y_ff <= next_y_in;
         ok_ff <= ok_in;
         done_ff <= done_in;
         fill_n_ff <= fill_n_in;
         fill_i_ff <= fill_i_in;
         cwidth_ff <= cwidth_in;
         cstart_ff <= cstart_in;
         crow_ff <= crow_in;
      end
   end

   assign done = done_ff;
   always_comb begin
      rsp_item.ok = ok_ff;
      rsp_item.read_word = word_ff;
      rsp_item.fault_code = fault_ff;
      rsp_item.fault_detail = detail_ff;
      rsp_item.advance = advance_ff;
      rsp_item.next_x = next_x_ff;
      rsp_item.next_y = next_y_ff;
      rsp_item.status_ready = budget_ff >= 24'd4;
      rsp_item.status_overflow = overflow_ff;
   end
endmodule

// File: src/surface_pixel_readback_unit.sv
// Surface pixel readback unit: configuration registers, front part, queue and
// back part. Depends on spru_pkg, spru_front, spru_queue, spru_back, assert_macros.svh.
//
// Usage: raise start with req_item while busy is low; the item is taken at
// that edge. Every item yields one result on rsp_item, marked by rsp_valid
// for one cycle; the receiver cannot stall, so results are never held.
// csr_valid/csr_ready with csr_index and csr_data write the frame budget
// (index 0) or the supported mode code (index 1); csr_ready is always high.
// Items other than a successful read are registered in the queue, then in the
// result registers; the back part takes one of them every cycle while no read
// is in progress. A read that hits the chunk cache goes through ST_HIT_RD and
// ST_HIT_DONE; a miss first refills up to 64 pixels in ST_FILL_WR, where the
// surface memory read of one pixel overlaps the cache write of the one before.
// A two-entry queue between front and back lets items be taken while a read
// works, so busy rises only when the queue is full.
// Synchronous reset clears the budget, registry, cache tags and results;
// surface memory and cache data keep their contents.
`include "assert_macros.svh"
module surface_pixel_readback_unit (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input spru_pkg::req_type req_item,
   output logic rsp_valid,
   output spru_pkg::rsp_type rsp_item,
   input logic csr_valid,
   output logic csr_ready,
   input logic csr_index,
   input logic [31:0] csr_data
);
   logic [23:0] budget_cfg_ff;
   logic [7:0] mode_cfg_ff;
   logic q_push, q_pop, q_full, q_empty;
   spru_pkg::entry_type q_entry, q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_cfg_ff <= 24'd65536;
         mode_cfg_ff <= 8'd0;
      end else if (csr_valid) begin
         if (csr_index == spru_pkg::CSR_FRAME_BUDGET) budget_cfg_ff <= csr_data[23:0];
         else mode_cfg_ff <= csr_data[7:0];
      end
   end

   spru_front u_front (
      .start(start), .req_item(req_item),
      .q_full(q_full), .busy(busy), .q_push(q_push), .q_entry(q_entry)
   );

   spru_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_entry(q_entry),
      .pop(q_pop), .full(q_full), .empty(q_empty), .head(q_head)
   );

   spru_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .head(q_head), .q_pop(q_pop),
      .frame_budget(budget_cfg_ff), .mode_code(mode_cfg_ff),
      .done(rsp_valid), .rsp_item(rsp_item)
   );

   `ASSERT_IMPLIES(a_no_push_full, clock, reset, q_full, !q_push)
   `ASSERT_IMPLIES(a_no_pop_empty, clock, reset, q_pop, !q_empty)
   `ASSERT_NEXT(a_pop_strobe, clock, reset, q_pop, rsp_valid)
endmodule
